[hw/rtl/bad_crc_gap_filler_unit_defines.svh]
// Shared assertion macros for the gap filler block.
`ifndef BAD_CRC_GAP_FILLER_UNIT_DEFINES_SVH
`define BAD_CRC_GAP_FILLER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BCGF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define BCGF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bcgf_pkg.sv]
`default_nettype none

package bcgf_pkg;

   localparam int GAP_BITS_DEF    = 16;
   localparam int COUNT_BITS_DEF  = 48;
   localparam int FIELD_BITS      = 16;
   localparam int FRAME_BITS      = 11;
   localparam int THRESH_BITS     = 17;
   localparam int TOTAL_OUT_BITS  = 48;
   localparam int KIND_BITS       = 2;

   localparam int MAX_FILLERS     = 47;
   localparam int FILL_CNT_BITS   = $clog2(MAX_FILLERS + 1);

   localparam int CHUNK_MAX        = 1538;
   localparam int CHUNK_HALF_ABOVE = 2000;
   localparam int LEN_OFFSET       = 20;
   localparam int BYTE_OFFSET      = 24;
   localparam int MIN_FLOOR        = 24;
   localparam int MIN_FRAME_RESET  = 84;

   localparam int QUEUE_DEPTH     = 4;

   // Register indexes on the csr port.
   localparam logic CSR_MIN_FRAME      = 1'b0;
   localparam logic CSR_LOSS_THRESHOLD = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_FILLER  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FORWARD = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DROP    = 2'd2;

   // One classified packet waiting for the back end.
   typedef struct packed {
      logic [FIELD_BITS-1:0] gap;
      logic                  drop;
      logic [FIELD_BITS-1:0] tag;
   } job_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]      kind;
      logic [FRAME_BITS-1:0]     frame_len;
      logic [FIELD_BITS-1:0]     tag_out;
      logic                      last;
      logic [TOTAL_OUT_BITS-1:0] filler_total;
      logic [TOTAL_OUT_BITS-1:0] filler_bytes_total;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

endpackage

`default_nettype wire

[hw/rtl/bcgf_front.sv]
`default_nettype none

module bcgf_front
   import bcgf_pkg::*;
#(
   parameter int GAP_BITS = GAP_BITS_DEF
) (
   input  wire logic [FIELD_BITS-1:0]  gap_bytes,
   input  wire logic [FIELD_BITS-1:0]  loss_draw,
   input  wire logic [FIELD_BITS-1:0]  packet_tag,
   input  wire logic [THRESH_BITS-1:0] loss_threshold,
   output job_type                     job
);

   localparam logic [FIELD_BITS-1:0] GAP_MAX = FIELD_BITS'((33'd1 << GAP_BITS) - 33'd1);

   always_comb begin
      job.gap  = (gap_bytes > GAP_MAX) ? GAP_MAX : gap_bytes;
      job.drop = ({1'b0, loss_draw} < loss_threshold);
      job.tag  = packet_tag;
   end

endmodule

`default_nettype wire

[hw/rtl/bcgf_queue.sv]
`default_nettype none

module bcgf_queue
   import bcgf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_data,
   output logic         not_empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   job_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bcgf_back.sv]
`default_nettype none

module bcgf_back
   import bcgf_pkg::*;
#(
   parameter int GAP_BITS   = GAP_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_valid,
   input  wire job_type               job,
   output logic                       job_pop,
   input  wire logic [FRAME_BITS-1:0] min_frame,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp
);

   localparam int TOTAL_BITS = ((GAP_BITS > FRAME_BITS) ? GAP_BITS : FRAME_BITS) + 1;

   back_state_type            state_ff, state_in;
   logic [GAP_BITS-1:0]       remaining_ff, remaining_in;
   logic [FRAME_BITS-1:0]     carry_ff, carry_in;
   logic [FILL_CNT_BITS-1:0]  nfill_ff, nfill_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [COUNT_BITS-1:0]     bytes_ff, bytes_in;
   logic                      drop_ff, drop_in;
   logic [FIELD_BITS-1:0]     tag_ff, tag_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [FRAME_BITS-1:0]     minf;
   logic [TOTAL_BITS-1:0]     total;
   logic [FRAME_BITS-1:0]     chunk;
   logic                      out_free;
   logic [COUNT_BITS+TOTAL_OUT_BITS-1:0] count_wide, bytes_wide;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign minf      = (min_frame < FRAME_BITS'(MIN_FLOOR)) ? FRAME_BITS'(MIN_FLOOR) : min_frame;
   assign total     = TOTAL_BITS'(remaining_ff) + TOTAL_BITS'(carry_ff);

   always_comb begin
      if (total < TOTAL_BITS'(CHUNK_MAX)) begin
         chunk = total[FRAME_BITS-1:0];
      end else if (total > TOTAL_BITS'(CHUNK_HALF_ABOVE)) begin
         chunk = FRAME_BITS'(CHUNK_MAX);
      end else begin
         chunk = total[FRAME_BITS:1];
      end
   end

   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      carry_in     = carry_ff;
      nfill_in     = nfill_ff;
      count_in     = count_ff;
      bytes_in     = bytes_ff;
      drop_in      = drop_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      job_pop      = 1'b0;
      count_wide   = '0;
      bytes_wide   = '0;

      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop      = 1'b1;
               remaining_in = job.gap[GAP_BITS-1:0];
               drop_in      = job.drop;
               tag_in       = job.tag;
               nfill_in     = '0;
               state_in     = BK_RUN;
            end
         end
         BK_RUN: begin
            if (out_free) begin
               if (remaining_ff != '0 && nfill_ff != FILL_CNT_BITS'(MAX_FILLERS)) begin
                  carry_in = '0;
                  if (total < TOTAL_BITS'(minf)) begin
                     // too short for a filler: hold it for the next packet
                     carry_in     = total[FRAME_BITS-1:0];
                     remaining_in = '0;
                  end else begin
                     if (TOTAL_BITS'(chunk) > TOTAL_BITS'(remaining_ff)) begin
                        remaining_in = '0;
                     end else begin
                        remaining_in = GAP_BITS'(TOTAL_BITS'(remaining_ff)
                                                 - TOTAL_BITS'(chunk));
                     end
                     nfill_in   = nfill_ff + 1'b1;
                     count_in   = count_ff + COUNT_BITS'(1);
                     // frame length plus 24 is chunk plus 4
                     bytes_in   = bytes_ff + COUNT_BITS'(chunk)
                                  + COUNT_BITS'(BYTE_OFFSET - LEN_OFFSET);
                     count_wide = {{TOTAL_OUT_BITS{1'b0}}, count_in};
                     bytes_wide = {{TOTAL_OUT_BITS{1'b0}}, bytes_in};
                     rsp_valid_in = 1'b1;
                     rsp_in.kind               = KIND_FILLER;
                     rsp_in.frame_len          = chunk - FRAME_BITS'(LEN_OFFSET);
                     rsp_in.tag_out            = '0;
                     rsp_in.last               = 1'b0;
                     rsp_in.filler_total       = count_wide[TOTAL_OUT_BITS-1:0];
                     rsp_in.filler_bytes_total = bytes_wide[TOTAL_OUT_BITS-1:0];
                  end
               end else begin
                  remaining_in = '0;
                  count_wide   = {{TOTAL_OUT_BITS{1'b0}}, count_ff};
                  bytes_wide   = {{TOTAL_OUT_BITS{1'b0}}, bytes_ff};
                  rsp_valid_in = 1'b1;
                  rsp_in.kind               = drop_ff ? KIND_DROP : KIND_FORWARD;
                  rsp_in.frame_len          = '0;
                  rsp_in.tag_out            = tag_ff;
                  rsp_in.last               = 1'b1;
                  rsp_in.filler_total       = count_wide[TOTAL_OUT_BITS-1:0];
                  rsp_in.filler_bytes_total = bytes_wide[TOTAL_OUT_BITS-1:0];
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         remaining_ff <= '0;
         carry_ff     <= '0;
         nfill_ff     <= '0;
         count_ff     <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         carry_ff     <= carry_in;
         nfill_ff     <= nfill_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff <= drop_in;
      tag_ff  <= tag_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

[hw/rtl/bad_crc_gap_filler_unit.sv]
// Bad-CRC gap filler. Each req transfer carries one real packet and the gap in wire bytes
// wanted before it; the block answers with zero or more filler frames (tuser = filler,
// tdata holds the length, chunk minus 20) and then one result for the packet itself,
// forward or drop, marked by tlast. Gap too short for one filler is carried into the
// next packet. Requests are classified on entry and wait in a four-deep queue, so the
// req side keeps taking packets while results are still being drained. The back end
// picks up a packet, sends its filler frames one at a time, keeps any leftover for
// the next packet, and then sends the packet result. A stall on rsp holds the back
// end in place. The csr registers take effect at once and are meant to be written
// with the block idle.
`default_nettype none

module bad_crc_gap_filler_unit
   import bcgf_pkg::*;
#(
   parameter int GAP_BITS   = GAP_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [47:0]            req_tdata,  // gap_bytes, loss_draw, packet_tag
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [127:0]                rsp_tdata,  // frame_len, tag_out, filler_total,
                                                   // filler_bytes_total, zero pad
   output logic [KIND_BITS-1:0]        rsp_tuser,  // kind
   output logic                        rsp_tlast,
   input  wire logic                   csr_we,
   input  wire logic                   csr_addr,
   input  wire logic [THRESH_BITS-1:0] csr_wdata
);

   logic [FRAME_BITS-1:0]  min_frame_ff;
   logic [THRESH_BITS-1:0] loss_threshold_ff;
   job_type                front_job, queue_job;
   logic                   queue_full, queue_valid, queue_pop;
   rsp_type                rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_frame_ff      <= FRAME_BITS'(MIN_FRAME_RESET);
         loss_threshold_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MIN_FRAME:      min_frame_ff      <= csr_wdata[FRAME_BITS-1:0];
            CSR_LOSS_THRESHOLD: loss_threshold_ff <= csr_wdata;
            default:            ;
         endcase
      end
   end

   bcgf_front #(
      .GAP_BITS(GAP_BITS)
   ) u_front (
      .gap_bytes     (req_tdata[15:0]),
      .loss_draw     (req_tdata[31:16]),
      .packet_tag    (req_tdata[47:32]),
      .loss_threshold(loss_threshold_ff),
      .job           (front_job)
   );

   assign req_tready = !queue_full;

   bcgf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_tvalid),
      .push_data(front_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_data (queue_job),
      .not_empty(queue_valid)
   );

   bcgf_back #(
      .GAP_BITS  (GAP_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(queue_valid),
      .job      (queue_job),
      .job_pop  (queue_pop),
      .min_frame(min_frame_ff),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp      (rsp)
   );

   assign rsp_tdata = {5'b0, rsp.filler_bytes_total, rsp.filler_total,
                       rsp.tag_out, rsp.frame_len};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire

[hw/rtl/bcgf_checker.sv]
`default_nettype none
`include "bad_crc_gap_filler_unit_defines.svh"

module bcgf_checker
   import bcgf_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [127:0]           rsp_tdata,
   input wire logic [KIND_BITS-1:0]   rsp_tuser,
   input wire logic                   rsp_tlast
);

   // A filler carries no tag, never ends the run, and is 4 to 1518 bytes long.
   `BCGF_ASSERT_NOW(a_filler_shape, rsp_tvalid && rsp_tuser == KIND_FILLER,
      !rsp_tlast && rsp_tdata[26:11] == '0 && rsp_tdata[10:0] >= 11'd4
      && rsp_tdata[10:0] <= 11'd1518, "filler result malformed")

   // The packet result closes the run and has no filler length.
   `BCGF_ASSERT_NOW(a_packet_shape, rsp_tvalid && rsp_tuser != KIND_FILLER,
      rsp_tlast && rsp_tdata[10:0] == '0, "packet result malformed")

   `BCGF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result changed")

endmodule

bind bad_crc_gap_filler_unit bcgf_checker u_bcgf_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bcgf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AT_RESULT = 150;
   localparam int MAX_PRINTED    = 40;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 48;

   // tdata packing of one request: gap in the lowest bits
   typedef struct packed {
      logic [FIELD_BITS-1:0] tag;
      logic [FIELD_BITS-1:0] draw;
      logic [FIELD_BITS-1:0] gap;
   } packet_req_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [47:0]            req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [127:0]           rsp_tdata;
   logic [KIND_BITS-1:0]   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic                   csr_addr = CSR_MIN_FRAME;
   logic [THRESH_BITS-1:0] csr_wdata = '0;

   bad_crc_gap_filler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the block's registers and state
   logic [FRAME_BITS-1:0]     cfg_min_frame = FRAME_BITS'(MIN_FRAME_RESET);
   logic [THRESH_BITS-1:0]    cfg_loss_thr  = '0;
   logic [FRAME_BITS-1:0]     carried_gap   = '0;
   logic [TOTAL_OUT_BITS-1:0] filler_frames = '0;
   logic [TOTAL_OUT_BITS-1:0] filler_octets = '0;

   packet_req_type pending_packets[$];
   rsp_type        expected_results[$];

   int packets_queued   = 0;
   int packets_accepted = 0;
   int results_checked  = 0;
   int fillers_checked  = 0;
   int drops_checked    = 0;
   int csr_writes       = 0;
   int mismatch_count   = 0;
   int req_idle_max     = 6;
   int rsp_idle_max     = 6;

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED)
         $display("[%0t] MISMATCH %s", $realtime, what);
      mismatch_count++;
   endtask

   // Splits the gap into filler chunks and queues the results this packet causes.
   task automatic plan_gap_fill(input packet_req_type p);
      logic [16:0]           remain;
      logic [16:0]           total;
      logic [16:0]           chunk;
      logic [FRAME_BITS-1:0] floor_min;
      rsp_type               r;
      int                    n;
      floor_min = (cfg_min_frame < MIN_FLOOR) ? FRAME_BITS'(MIN_FLOOR) : cfg_min_frame;
      remain = {1'b0, p.gap};
      n = 0;
      while (remain != 0 && n < MAX_FILLERS) begin
         total = remain + carried_gap;
         carried_gap = '0;
         if (total < floor_min) begin
            carried_gap = total[FRAME_BITS-1:0];
            break;
         end
         if (total < CHUNK_MAX)
            chunk = total;
         else if (total > CHUNK_HALF_ABOVE)
            chunk = 17'(CHUNK_MAX);
         else
            chunk = total >> 1;
         remain = (chunk > remain) ? 17'd0 : remain - chunk;
         r.kind = KIND_FILLER;
         r.frame_len = FRAME_BITS'(chunk - LEN_OFFSET);
         r.tag_out = '0;
         r.last = 1'b0;
         filler_frames = filler_frames + 1;
         filler_octets = filler_octets + r.frame_len + BYTE_OFFSET;
         r.filler_total = filler_frames;
         r.filler_bytes_total = filler_octets;
         expected_results.push_back(r);
         n++;
      end
      r.kind = ({1'b0, p.draw} < cfg_loss_thr) ? KIND_DROP : KIND_FORWARD;
      r.frame_len = '0;
      r.tag_out = p.tag;
      r.last = 1'b1;
      r.filler_total = filler_frames;
      r.filler_bytes_total = filler_octets;
      expected_results.push_back(r);
   endtask

   task automatic queue_packet(input int gap, input int draw, input int tag);
      packet_req_type p;
      p.gap = gap[15:0];
      p.draw = draw[15:0];
      p.tag = tag[15:0];
      pending_packets.push_back(p);
      packets_queued++;
   endtask

   function automatic packet_req_type random_packet();
      packet_req_type p;
      int             sel;
      int             floor_min;
      int             near;
      floor_min = (cfg_min_frame < MIN_FLOOR) ? MIN_FLOOR : int'(cfg_min_frame);
      sel = $urandom_range(0, 99);
      if (sel < 10)
         p.gap = '0;
      else if (sel < 45)
         p.gap = 16'($urandom_range(1, 200));
      else if (sel < 65)
         p.gap = 16'($urandom_range(200, 2100));
      else if (sel < 80)
         p.gap = 16'($urandom_range(2000, 8000));
      else if (sel < 88)
         p.gap = 16'($urandom);
      else begin
         case ($urandom_range(0, 8))
            0: p.gap = 16'd1;
            1: p.gap = 16'(floor_min - 1);
            2: p.gap = 16'(floor_min);
            3: p.gap = 16'd1537;
            4: p.gap = 16'd1538;
            5: p.gap = 16'd1539;
            6: p.gap = 16'd2000;
            7: p.gap = 16'd2001;
            default: p.gap = 16'hFFFF;
         endcase
      end
      // some draws land at or just below the loss threshold
      if ($urandom_range(0, 4) == 0) begin
         near = int'(cfg_loss_thr) - int'($urandom_range(0, 1));
         if (near < 0) near = 0;
         if (near > 65535) near = 65535;
         p.draw = 16'(near);
      end else
         p.draw = 16'($urandom);
      p.tag = 16'($urandom);
      return p;
   endfunction

   task automatic csr_write(input logic addr, input logic [THRESH_BITS-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      if (addr == CSR_MIN_FRAME)
         cfg_min_frame = value[FRAME_BITS-1:0];
      else
         cfg_loss_thr = value;
      csr_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (packets_accepted != packets_queued || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   packet_req_type req_item;
   int             req_gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            plan_gap_fill(req_item);
            packets_accepted++;
            req_gap_left = $urandom_range(0, req_idle_max);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_packets.size() > 0) begin
               req_item = pending_packets.pop_front();
               req_tdata <= req_item;
               req_tvalid <= 1'b1;
            end else
               req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor and receiver stalls
   int  rsp_gap_left = 0;
   int  long_hold_left = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_type got;
      rsp_type exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.frame_len = rsp_tdata[10:0];
            got.tag_out = rsp_tdata[26:11];
            got.last = rsp_tlast;
            got.filler_total = rsp_tdata[74:27];
            got.filler_bytes_total = rsp_tdata[122:75];
            if (expected_results.size() == 0)
               report_mismatch($sformatf("result with nothing pending, kind %0d tag %0h",
                                         got.kind, got.tag_out));
            else begin
               exp = expected_results.pop_front();
               if (got.kind !== exp.kind)
                  report_mismatch($sformatf("result %0d kind got %0d exp %0d",
                                            results_checked, got.kind, exp.kind));
               if (got.frame_len !== exp.frame_len)
                  report_mismatch($sformatf("result %0d frame_len got %0d exp %0d",
                                            results_checked, got.frame_len, exp.frame_len));
               if (got.tag_out !== exp.tag_out)
                  report_mismatch($sformatf("result %0d tag_out got %0h exp %0h",
                                            results_checked, got.tag_out, exp.tag_out));
               if (got.last !== exp.last)
                  report_mismatch($sformatf("result %0d last got %0b exp %0b",
                                            results_checked, got.last, exp.last));
               if (got.filler_total !== exp.filler_total)
                  report_mismatch($sformatf("result %0d filler_total got %0d exp %0d",
                                            results_checked, got.filler_total,
                                            exp.filler_total));
               if (got.filler_bytes_total !== exp.filler_bytes_total)
                  report_mismatch($sformatf("result %0d filler_bytes_total got %0d exp %0d",
                                            results_checked, got.filler_bytes_total,
                                            exp.filler_bytes_total));
               if (exp.kind == KIND_FILLER) fillers_checked++;
               if (exp.kind == KIND_DROP) drops_checked++;
            end
            results_checked++;
            rsp_gap_left = $urandom_range(0, rsp_idle_max);
         end
         // one long back-pressure stretch so the request queue fills up
         if (!long_hold_done && results_checked >= HOLD_AT_RESULT) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= 1'b1;
      end
   end

   // watchdog: cycles without any transfer
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
                  $realtime, idle_cycles, expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [FRAME_BITS-1:0]  min_sets[RANDOM_PHASES];
      logic [THRESH_BITS-1:0] thr_sets[RANDOM_PHASES];
      int                     idle_sets[RANDOM_PHASES];
      min_sets  = '{11'd84, 11'd24, 11'd0, 11'd1538, 11'd2047, 11'd200, 11'd0, 11'd60};
      thr_sets  = '{17'd0, 17'd65536, 17'd32768, 17'd1, 17'd65535, 17'd0, 17'd20000, 17'd0};
      idle_sets = '{6, 0, 6, 2, 6, 0, 6, 3};
      min_sets[6] = 11'($urandom_range(24, 1538));
      thr_sets[5] = 17'($urandom_range(0, 65536));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers; carry, zero gap and chunk boundaries
      queue_packet(0, 0, 0);
      queue_packet(50, 16'hFFFF, 16'hFFFF);
      queue_packet(0, 1, 16'h0001);
      queue_packet(40, 2, 16'h8000);
      queue_packet(83, 3, 16'h1234);
      queue_packet(1, 4, 16'h4321);
      queue_packet(84, 5, 16'h00FF);
      queue_packet(1537, 6, 16'hFF00);
      queue_packet(1538, 7, 16'h5A5A);
      queue_packet(1539, 8, 16'hA5A5);
      queue_packet(2000, 9, 16'h0F0F);
      queue_packet(2001, 10, 16'hF0F0);
      queue_packet(3076, 11, 16'h7FFF);
      queue_packet(65535, 16'h8000, 16'hFFFE);
      wait_drained();

      // min_frame below the floor, every packet dropped
      csr_write(CSR_MIN_FRAME, 17'd0);
      csr_write(CSR_LOSS_THRESHOLD, 17'd65536);
      queue_packet(23, 16'hFFFF, 16'h0002);
      queue_packet(1, 0, 16'h0003);
      queue_packet(4, 16'h7FFF, 16'h0004);
      queue_packet(24, 16'hFFFF, 16'h0005);
      wait_drained();

      // largest chunk floor: carry up to it, then halves
      csr_write(CSR_MIN_FRAME, 17'd1538);
      csr_write(CSR_LOSS_THRESHOLD, 17'd1);
      queue_packet(1537, 0, 16'h0006);
      queue_packet(1, 1, 16'h0007);
      queue_packet(0, 0, 16'h0008);
      queue_packet(3000, 0, 16'h0009);
      wait_drained();

      csr_write(CSR_MIN_FRAME, 17'd2047);
      csr_write(CSR_LOSS_THRESHOLD, 17'd65535);
      queue_packet(2046, 16'hFFFE, 16'h000A);
      queue_packet(1, 16'hFFFF, 16'h000B);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         csr_write(CSR_MIN_FRAME, {6'd0, min_sets[ph]});
         csr_write(CSR_LOSS_THRESHOLD, thr_sets[ph]);
         req_idle_max = idle_sets[ph];
         rsp_idle_max = idle_sets[(ph + 3) % RANDOM_PHASES];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pending_packets.push_back(random_packet());
            packets_queued++;
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d packets, %0d results (%0d fillers, %0d drops)",
               packets_accepted, results_checked, fillers_checked, drops_checked);
      $display("over %0d register writes, min_frame and loss threshold at both extremes",
               csr_writes);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
